FILE: sv/trw_pkg.sv
package trw_pkg;

  localparam int ROWS_MAX = 16;
  localparam int COLS_MAX = 32;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [3:0] row;
    logic [5:0] col;
  } unit_req_t;

  typedef struct packed {
    logic [3:0] row_adv;  // next row of the ring
    logic [5:0] col_inc;  // col + 1
    logic       fits;     // col < cols
    logic       at_end;   // col + 1 >= cols
  } unit_rsp_t;

endpackage

FILE: sv/trw_if.sv
interface trw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       wrap_mode;
  logic       end_of_string;

  modport source (output valid, ch, wrap_mode, end_of_string, input ready);
  modport sink (input valid, ch, wrap_mode, end_of_string, output ready);
endinterface

interface trw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] row;
  logic [4:0] col;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, row, col, out_char, last_of_run, input ready);
  modport sink (input valid, row, col, out_char, last_of_run, output ready);
endinterface

FILE: sv/trw_unit.sv
module trw_unit (
  input  trw_pkg::unit_req_t req,
  input  logic [4:0]         eff_rows,
  input  logic [5:0]         eff_cols,
  output trw_pkg::unit_rsp_t rsp
);
  import trw_pkg::*;

  logic [4:0] row_inc;

  always_comb begin
    row_inc     = {1'b0, req.row} + 5'd1;
    rsp.row_adv = (row_inc >= eff_rows) ? 4'd0 : row_inc[3:0];
    rsp.col_inc = req.col + 6'd1;
    rsp.fits    = (req.col < eff_cols);
    rsp.at_end  = (rsp.col_inc >= eff_cols);
  end

endmodule

FILE: sv/trw_seq.sv
module trw_seq (
  input  logic               clk,
  input  logic               rst,
  trw_in_if.sink             char_in,
  trw_out_if.source          wr_out,
  output trw_pkg::unit_req_t req,
  input  trw_pkg::unit_rsp_t rsp
);
  import trw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAR = 2'd1;
  localparam logic [1:0] S_PAD  = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] cur_row, cur_row_next;
  logic [5:0] cur_col, cur_col_next;
  logic       latched_mode, latched_mode_next;
  logic       mid_string, mid_string_next;
  logic [7:0] chr_q, chr_q_next;
  logic       last_q, last_q_next;

  logic       ovalid;
  logic [3:0] orow;
  logic [4:0] ocol;
  logic [7:0] ochar;
  logic       olast;

  logic       load_ok;
  logic       emit;
  logic [7:0] e_char;
  logic       e_last;

  assign load_ok       = !ovalid || wr_out.ready;
  assign char_in.ready = (state == S_IDLE);
  assign req.row       = cur_row;
  assign req.col       = cur_col;

  assign wr_out.valid       = ovalid;
  assign wr_out.row         = orow;
  assign wr_out.col         = ocol;
  assign wr_out.out_char    = ochar;
  assign wr_out.last_of_run = olast;

  always_comb begin
    state_next        = state;
    cur_row_next      = cur_row;
    cur_col_next      = cur_col;
    latched_mode_next = latched_mode;
    mid_string_next   = mid_string;
    chr_q_next        = chr_q;
    last_q_next       = last_q;
    emit              = 1'b0;
    e_char            = chr_q;
    e_last            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (char_in.valid) begin
          chr_q_next  = char_in.ch;
          last_q_next = char_in.end_of_string;
          if (!mid_string) begin
            latched_mode_next = char_in.wrap_mode;
            cur_col_next      = 6'd0;
            mid_string_next   = 1'b1;
          end
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        if (!latched_mode) begin
          if (rsp.fits) begin
            if (load_ok) begin
              emit         = 1'b1;
              e_last       = !last_q || rsp.at_end;
              cur_col_next = rsp.col_inc;
              state_next   = S_IDLE;
              if (last_q && rsp.at_end) begin
                cur_row_next    = rsp.row_adv;
                cur_col_next    = 6'd0;
                mid_string_next = 1'b0;
              end else if (last_q) begin
                state_next = S_PAD;
              end
            end
          end else begin
            // past the last column: drop, and close the string on the end mark
            if (last_q) begin
              cur_row_next    = rsp.row_adv;
              cur_col_next    = 6'd0;
              mid_string_next = 1'b0;
            end
            state_next = S_IDLE;
          end
        end else begin
          if (!rsp.fits) begin
            // row full: move on and clear the new row before the character
            cur_row_next = rsp.row_adv;
            cur_col_next = 6'd0;
            state_next   = S_CLR;
          end else if (load_ok) begin
            emit         = 1'b1;
            e_last       = 1'b1;
            cur_col_next = rsp.col_inc;
            state_next   = S_IDLE;
            if (last_q) begin
              cur_row_next    = rsp.row_adv;
              cur_col_next    = 6'd0;
              mid_string_next = 1'b0;
            end
          end
        end
      end
      S_PAD: begin
        if (load_ok) begin
          emit         = 1'b1;
          e_char       = SPACE_CHAR;
          e_last       = rsp.at_end;
          cur_col_next = rsp.col_inc;
          if (rsp.at_end) begin
            cur_row_next    = rsp.row_adv;
            cur_col_next    = 6'd0;
            mid_string_next = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (load_ok) begin
          emit         = 1'b1;
          e_char       = SPACE_CHAR;
          cur_col_next = rsp.col_inc;
          if (rsp.at_end) begin
            cur_col_next = 6'd0;
            state_next   = S_CHAR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_row      <= 4'd0;
      cur_col      <= 6'd0;
      latched_mode <= 1'b0;
      mid_string   <= 1'b0;
      ovalid       <= 1'b0;
    end else begin
      state        <= state_next;
      cur_row      <= cur_row_next;
      cur_col      <= cur_col_next;
      latched_mode <= latched_mode_next;
      mid_string   <= mid_string_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (wr_out.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chr_q  <= chr_q_next;
    last_q <= last_q_next;
    if (emit) begin
      orow  <= cur_row;
      ocol  <= cur_col[4:0];
      ochar <= e_char;
      olast <= e_last;
    end
  end

`ifndef SYNTH
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cur_col <= 6'(COLS_MAX))
    else $error("column counter out of range");

  a_pad_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAD || state == S_CLR) |-> rsp.fits)
    else $error("pad or clear past the last column");

  a_idle_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !mid_string) |-> (cur_col == 6'd0))
    else $error("column not cleared between strings");

  a_accept_work: assert property (@(posedge clk) disable iff (rst)
    (char_in.valid && char_in.ready) |=> (state == S_CHAR && mid_string))
    else $error("accepted word not taken into work");
`endif

endmodule

FILE: sv/text_row_writer_truncate_wrap.sv
// A write leaves on wr_out from the output register after the word reaches S_CHAR.
// Words go through the column/row unit one at a time; a new word is taken only in S_IDLE.
// A string end in truncate mode pads the rest of the row with spaces.
// A full row in wrap mode advances a row and clears it with spaces before the character.
// Reset (rst, synchronous): rows and columns registers to 1, row 0, column 0, no string open.
module text_row_writer_truncate_wrap (
  input  logic       clk,
  input  logic       rst,
  trw_in_if.sink     char_in,
  trw_out_if.source  wr_out,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [5:0] wr_data
);
  import trw_pkg::*;

  logic [4:0] rows_in_use;
  logic [5:0] cols_in_use;
  logic [4:0] eff_rows;
  logic [5:0] eff_cols;

  unit_req_t req;
  unit_rsp_t rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 5'd1;
      cols_in_use <= 6'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROWS: rows_in_use <= wr_data[4:0];
        REG_COLS: cols_in_use <= wr_data;
        default:  ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (rows_in_use == 5'd0) begin
      eff_rows = 5'd1;
    end else if (rows_in_use > 5'(ROWS_MAX)) begin
      eff_rows = 5'(ROWS_MAX);
    end else begin
      eff_rows = rows_in_use;
    end
    if (cols_in_use == 6'd0) begin
      eff_cols = 6'd1;
    end else if (cols_in_use > 6'(COLS_MAX)) begin
      eff_cols = 6'(COLS_MAX);
    end else begin
      eff_cols = cols_in_use;
    end
  end

  trw_unit u_unit (
    .req      (req),
    .eff_rows (eff_rows),
    .eff_cols (eff_cols),
    .rsp      (rsp)
  );

  trw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .wr_out  (wr_out),
    .req     (req),
    .rsp     (rsp)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import trw_pkg::*;

  localparam logic MODE_TRUNC = 1'b0;
  localparam logic MODE_WRAP  = 1'b1;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int PHASE_WORDS  = 51;
  localparam int PHASES       = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       wrap_mode;
    logic       end_of_string;
  } char_word_t;

  typedef struct packed {
    logic [3:0] row;
    logic [4:0] col;
    logic [7:0] out_char;
    logic       last_of_run;
  } disp_write_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic       wr_index;
  logic [5:0] wr_data;

  trw_in_if  char_in();
  trw_out_if wr_out();

  text_row_writer_truncate_wrap DUT (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .wr_out   (wr_out),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  char_word_t  word_queue[$];
  disp_write_t pending_writes[$];

  int pushed_words   = 0;
  int accepted_words = 0;
  int errors         = 0;
  int cycle_count    = 0;
  int hold_requests  = 0;

  // rows values wider than 5 bits check the register masking
  logic [5:0] rows_set [PHASES] = '{6'd16, 6'd5, 6'd2, 6'd31, 6'd1, 6'd48, 6'd8, 6'd0};
  logic [5:0] cols_set [PHASES] = '{6'd32, 6'd7, 6'd3, 6'd63, 6'd1, 6'd9, 6'd12, 6'd0};

  // shadow registers and writer state
  logic [4:0] rows_reg    = 5'd1;
  logic [5:0] cols_reg    = 6'd1;
  logic [3:0] row_now     = 4'd0;
  logic [5:0] col_now     = 6'd0;
  logic       string_wrap = MODE_TRUNC;
  logic       in_string   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned rows_eff();
    if (rows_reg == 5'd0) return 1;
    if (rows_reg > ROWS_MAX) return ROWS_MAX;
    return rows_reg;
  endfunction

  function automatic int unsigned cols_eff();
    if (cols_reg == 6'd0) return 1;
    if (cols_reg > COLS_MAX) return COLS_MAX;
    return cols_reg;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic add_write(input logic [3:0] r, input int unsigned c, input logic [7:0] chr);
    pending_writes.push_back('{row: r, col: c[4:0], out_char: chr, last_of_run: 1'b0});
  endtask

  task automatic next_row();
    if (int'(row_now) + 1 >= int'(rows_eff())) row_now = 4'd0;
    else row_now = row_now + 4'd1;
  endtask

  task automatic predict_writes(input logic [7:0] chr, input logic mode, input logic eos);
    int unsigned ncols;
    int          first;
    ncols = cols_eff();
    first = pending_writes.size();
    if (!in_string) begin
      string_wrap = mode;
      col_now = 6'd0;
      in_string = 1'b1;
    end
    if (string_wrap == MODE_TRUNC) begin
      // past the last column the word is dropped
      if (col_now < ncols) begin
        add_write(row_now, col_now, chr);
        col_now++;
      end
      if (eos) begin
        for (int unsigned j = col_now; j < ncols; j++) add_write(row_now, j, SPACE_CHAR);
        next_row();
      end
    end else begin
      // full row: advance and blank the new row first
      if (col_now >= ncols) begin
        next_row();
        for (int unsigned j = 0; j < ncols; j++) add_write(row_now, j, SPACE_CHAR);
        col_now = 6'd0;
      end
      add_write(row_now, col_now, chr);
      col_now++;
      if (eos) next_row();
    end
    if (eos) begin
      in_string = 1'b0;
      col_now = 6'd0;
    end
    if (pending_writes.size() > first)
      pending_writes[pending_writes.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic push_word(input logic [7:0] chr, input logic mode, input logic eos);
    word_queue.push_back('{ch: chr, wrap_mode: mode, end_of_string: eos});
    pushed_words++;
  endtask

  task automatic set_config(input logic [5:0] rows_val, input logic [5:0] cols_val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_ROWS;
    wr_data <= rows_val;
    @(posedge clk);
    wr_index <= REG_COLS;
    wr_data <= cols_val;
    @(posedge clk);
    wr_en <= 1'b0;
    rows_reg = rows_val[4:0];
    cols_reg = cols_val;
  endtask

  // wait for every word taken and every write seen, then let trailing words finish
  task automatic settle();
    while (accepted_words != pushed_words || pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_chars
    int         burst_left;
    int         gap_left;
    logic       offer;
    char_word_t w;
    if (rst) begin
      char_in.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!char_in.valid || char_in.ready) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_queue.size() != 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        offer = 1'b1;
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      char_in.valid <= offer;
      if (offer) begin
        w = word_queue.pop_front();
        char_in.ch <= w.ch;
        char_in.wrap_mode <= w.wrap_mode;
        char_in.end_of_string <= w.end_of_string;
      end
    end
  end

  always @(posedge clk) begin : stall_writes
    int         hold_left;
    int         holds_done;
    int         pat_age;
    logic [7:0] stall_bits;
    logic       rdy;
    if (rst) begin
      wr_out.ready <= 1'b0;
      hold_left = 0;
      holds_done = 0;
      pat_age = 0;
      stall_bits = 8'hFF;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        if (pat_age == 0) begin
          pat_age = 48;
          stall_bits = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom | 32'h1);
        end
        pat_age--;
        rdy = stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[7:1]};
      end
      wr_out.ready <= rdy;
    end
  end

  always @(posedge clk) begin : watch_ports
    disp_write_t want;
    if (!rst) begin
      if (char_in.valid && char_in.ready) begin
        accepted_words++;
        predict_writes(char_in.ch, char_in.wrap_mode, char_in.end_of_string);
      end
      if (wr_out.valid && wr_out.ready) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("write with none pending, row", wr_out.row, -1);
        end else begin
          want = pending_writes.pop_front();
          if (wr_out.row !== want.row) report_mismatch("row", wr_out.row, want.row);
          if (wr_out.col !== want.col) report_mismatch("col", wr_out.col, want.col);
          if (wr_out.out_char !== want.out_char)
            report_mismatch("out_char", wr_out.out_char, want.out_char);
          if (wr_out.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", wr_out.last_of_run, want.last_of_run);
        end
      end
    end
  end

  initial begin : stimulus
    int          budget;
    int          len;
    int unsigned ncols;
    logic        mode;
    logic [7:0]  chr;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_ROWS;
    wr_data = 6'd0;
    char_in.valid = 1'b0;
    char_in.ch = 8'h00;
    char_in.wrap_mode = MODE_TRUNC;
    char_in.end_of_string = 1'b0;
    wr_out.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_config(6'd3, 6'd4);
    // zero byte is an ordinary character; mode on later words is ignored
    push_word(8'h00, MODE_TRUNC, 1'b0);
    push_word(8'hFF, MODE_WRAP, 1'b1);
    for (int i = 0; i < 9; i++) push_word(8'(8'h61 + i), MODE_WRAP, i == 8);
    // fifth word overflows the row and is dropped
    for (int i = 0; i < 5; i++) push_word(8'(8'h41 + i), MODE_TRUNC, i == 4);
    push_word(8'h80, MODE_WRAP, 1'b0);
    push_word(8'h7F, MODE_TRUNC, 1'b0);
    push_word(8'h01, MODE_TRUNC, 1'b0);
    settle();
    // shrink the ring mid-string: current row is now past the count
    set_config(6'd1, 6'd8);
    push_word(8'hAA, MODE_TRUNC, 1'b0);
    settle();
    // shrink the width mid-string: column is past the new width
    set_config(6'd2, 6'd2);
    push_word(8'h55, MODE_TRUNC, 1'b1);
    push_word(SPACE_CHAR, MODE_TRUNC, 1'b1);
    settle();
    set_config(6'd0, 6'd0);
    push_word(8'h78, MODE_WRAP, 1'b0);
    push_word(8'h79, MODE_TRUNC, 1'b1);
    settle();
    set_config(6'd31, 6'd63);
    push_word(8'h7E, MODE_TRUNC, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_config(rows_set[p], cols_set[p]);
      budget = PHASE_WORDS;
      while (budget > 0) begin
        ncols = cols_eff();
        if ($urandom_range(0, 3) == 0) len = $urandom_range(ncols + 1, 2 * ncols + 2);
        else len = $urandom_range(1, 6);
        mode = 1'($urandom_range(0, 1));
        // the last string of a phase may stay open across the reconfiguration
        for (int i = 0; i < len && budget > 0; i++) begin
          case ($urandom_range(0, 7))
            0: chr = 8'h00;
            1: chr = 8'hFF;
            2: chr = SPACE_CHAR;
            default: chr = 8'($urandom);
          endcase
          push_word(chr, (i == 0) ? mode : logic'($urandom_range(0, 1)), i == len - 1);
          budget--;
        end
      end
      // hold the write port off while the whole phase is queued
      if (p == 0 || p == 4) hold_requests++;
    end

    settle();
    if (pending_writes.size() != 0)
      report_mismatch("writes never seen", pending_writes.size(), 0);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
sv/trw_pkg.sv
sv/trw_if.sv
sv/trw_unit.sv
sv/trw_seq.sv
sv/text_row_writer_truncate_wrap.sv
tb/sv/testbench.sv
